// File: rtl/core/olpr_pkg.sv
// ----------------------------------------------------------------------------
// olpr_pkg
// Shared constants for the ordered list: field widths, opcodes, status codes
// and the default store depth.
// ----------------------------------------------------------------------------
package olpr_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE     = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

endpackage

// File: rtl/core/olpr_ram.sv
// ----------------------------------------------------------------------------
// olpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module olpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/ordered_list_push_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_push_remove
// Ordered list of signed 32-bit values held in a circular RAM store.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_opcode and in_item_value; the item is taken at a
//   clock edge where start is high and busy is low. Opcodes: push at front,
//   push at back, remove the first entry equal to in_item_value.
//   Every item gives exactly one result: out_valid is high for one cycle
//   with out_status and out_entry_count (entries held afterwards).
//   Pushes and unused opcodes: result in the cycle after acceptance, and
//   busy stays low, so one item per cycle.
//   Remove: the search reads one entry at a time through the single RAM
//   read port, then the entries behind the match move forward one slot
//   at a time (read, write back); busy is high until the result is
//   shown.
//   A new item may be started in the cycle the result is shown.
//   Reset (rst_n low, synchronous) empties the list; the RAM is not
//   cleared, only written entries are ever read.
//   The result cannot be stalled; the receiver must take it.
// ----------------------------------------------------------------------------
module ordered_list_push_remove #(
  parameter int CAPACITY = olpr_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [olpr_pkg::OP_W-1:0]    in_opcode,
  input  logic signed [olpr_pkg::DATA_W-1:0] in_item_value,
  output logic                         out_valid,
  output logic [olpr_pkg::STAT_W-1:0]  out_status,
  output logic [olpr_pkg::COUNT_W-1:0] out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = AW + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRD  = 5'b00010,
    S_SCMP = 5'b00100,
    S_MRD  = 5'b01000,
    S_MWR  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   front_r, front_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [olpr_pkg::DATA_W-1:0]     val_r, val_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [olpr_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [olpr_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [AW-1:0]                   mem_raddr;
  logic [olpr_pkg::DATA_W-1:0]     mem_wdata;
  logic [olpr_pkg::DATA_W-1:0]     mem_rdata;

  logic [CW-1:0]                   idx_inc;
  logic [CW-1:0]                   idx_inc2;
  logic [CW-1:0]                   count_inc;
  logic [CW-1:0]                   count_dec;
  logic [AW-1:0]                   front_dec;

  // Map a list offset to its slot in the circular store.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                            input logic [CW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(front) + SW'(offset);
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[AW-1:0];
  endfunction

  assign idx_inc   = idx_r + 1'b1;
  assign idx_inc2  = idx_inc + 1'b1;
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = slot_of(front_r, idx_r);
    mem_wdata      = mem_rdata;
    mem_raddr      = slot_of(front_r, idx_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt        = in_item_value;
          out_status_nxt = olpr_pkg::STAT_DONE;
          out_count_nxt  = olpr_pkg::COUNT_W'(count_r);
          unique case (in_opcode)
            olpr_pkg::OP_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (count_r == CAP_C) begin
                out_status_nxt = olpr_pkg::STAT_FULL;
              end else begin
                front_nxt     = front_dec;
                mem_we        = 1'b1;
                mem_waddr     = front_dec;
                mem_wdata     = in_item_value;
                count_nxt     = count_inc;
                out_count_nxt = olpr_pkg::COUNT_W'(count_inc);
              end
            end
            olpr_pkg::OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == CAP_C) begin
                out_status_nxt = olpr_pkg::STAT_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = slot_of(front_r, count_r);
                mem_wdata     = in_item_value;
                count_nxt     = count_inc;
                out_count_nxt = olpr_pkg::COUNT_W'(count_inc);
              end
            end
            olpr_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = olpr_pkg::STAT_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SRD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (mem_rdata == val_r) begin
          if (idx_inc < count_r) begin
            state_nxt = S_MRD;
          end else begin
            count_nxt      = count_dec;
            out_valid_nxt  = 1'b1;
            out_status_nxt = olpr_pkg::STAT_DONE;
            out_count_nxt  = olpr_pkg::COUNT_W'(count_dec);
            state_nxt      = S_IDLE;
          end
        end else if (idx_inc == count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = olpr_pkg::STAT_NOT_FOUND;
          out_count_nxt  = olpr_pkg::COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRD;
        end
      end
      S_MRD: begin
        // fetch the entry behind the gap
        mem_raddr = slot_of(front_r, idx_inc);
        state_nxt = S_MWR;
      end
      S_MWR: begin
        // close the gap by one slot
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
        if (idx_inc2 < count_r) begin
          state_nxt = S_MRD;
        end else begin
          count_nxt      = count_dec;
          out_valid_nxt  = 1'b1;
          out_status_nxt = olpr_pkg::STAT_DONE;
          out_count_nxt  = olpr_pkg::COUNT_W'(count_dec);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  olpr_ram #(
    .WIDTH(olpr_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_full_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == olpr_pkg::STAT_FULL) |-> count_r == CAP_C)
    else $error("full status with room left");

  a_result_has_cause : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(start) || $past(state_r != S_IDLE)))
    else $error("result without an accepted item");

  a_remove_drops_one : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && out_valid_nxt && out_status_nxt == olpr_pkg::STAT_DONE)
      |=> count_r == $past(count_dec))
    else $error("completed removal did not drop count by one");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list: pushes at both ends, removal of the
// first matching value and the unused opcode are driven through the start/busy
// handshake, and every result is compared with a queue-based prediction of the list.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIST_DEPTH = olpr_pkg::CAPACITY_DEF;
  localparam logic [olpr_pkg::OP_W-1:0] OP_NOP = 2'd3;  // unused opcode, no operation
  localparam int MAX_GAP = 12;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

  typedef struct packed {
    logic [olpr_pkg::STAT_W-1:0]  status;
    logic [olpr_pkg::COUNT_W-1:0] entry_count;
  } list_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic [olpr_pkg::OP_W-1:0]          in_opcode = '0;
  logic signed [olpr_pkg::DATA_W-1:0] in_item_value = '0;
  logic                               busy;
  logic                               out_valid;
  logic [olpr_pkg::STAT_W-1:0]        out_status;
  logic [olpr_pkg::COUNT_W-1:0]       out_entry_count;

  logic signed [olpr_pkg::DATA_W-1:0] model_list[$];
  list_result_t                       pending_results[$];
  int                                 err_count = 0;
  bit                                 burst_mode = 1'b0;

  ordered_list_push_remove #(.CAPACITY(LIST_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always #5 clk = ~clk;

  // Apply one request to the predicted list and return the expected result.
  function automatic list_result_t apply_list_op(
    input logic [olpr_pkg::OP_W-1:0] op,
    input logic signed [olpr_pkg::DATA_W-1:0] v);
    list_result_t r;
    int hit;
    r.status = olpr_pkg::STAT_DONE;
    hit = -1;
    case (op)
      olpr_pkg::OP_PUSH_FRONT: begin
        if (model_list.size() >= LIST_DEPTH) r.status = olpr_pkg::STAT_FULL;
        else model_list.push_front(v);
      end
      olpr_pkg::OP_PUSH_BACK: begin
        if (model_list.size() >= LIST_DEPTH) r.status = olpr_pkg::STAT_FULL;
        else model_list.push_back(v);
      end
      olpr_pkg::OP_REMOVE: begin
        foreach (model_list[i])
          if (hit < 0 && model_list[i] === v) hit = i;
        if (hit < 0) r.status = olpr_pkg::STAT_NOT_FOUND;
        else model_list.delete(hit);
      end
      default: ;
    endcase
    r.entry_count = olpr_pkg::COUNT_W'(model_list.size());
    return r;
  endfunction

  // Drive one item, hold it until taken, then record its expected result.
  task automatic issue_request(input logic [olpr_pkg::OP_W-1:0] op,
                               input logic signed [olpr_pkg::DATA_W-1:0] v);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_item_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_list_op(op, v));
    if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [olpr_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) - 4;  // small pool, gives duplicates
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a value present in the list, else anything.
  function automatic logic signed [olpr_pkg::DATA_W-1:0] pick_removal();
    if (model_list.size() != 0 && $urandom_range(0, 9) < 7)
      return model_list[$urandom_range(0, model_list.size() - 1)];
    return pick_value();
  endfunction

  function automatic logic [olpr_pkg::OP_W-1:0] pick_push();
    return $urandom_range(0, 1) ? olpr_pkg::OP_PUSH_BACK : olpr_pkg::OP_PUSH_FRONT;
  endfunction

  task automatic test_directed();
    issue_request(olpr_pkg::OP_REMOVE, -5);  // empty list
    issue_request(OP_NOP, 32'sh1234_5678);
    issue_request(olpr_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
    issue_request(olpr_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    issue_request(olpr_pkg::OP_PUSH_BACK, 0);
    issue_request(olpr_pkg::OP_PUSH_FRONT, -1);
    issue_request(olpr_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
    issue_request(olpr_pkg::OP_PUSH_BACK, 32'shAAAA_AAAA);
    issue_request(olpr_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
    issue_request(OP_NOP, -1);
    issue_request(olpr_pkg::OP_REMOVE, 32'sh7FFF_FFFF);  // first of two equal entries
    issue_request(olpr_pkg::OP_REMOVE, 12345);
    issue_request(olpr_pkg::OP_REMOVE, 32'sh7FFF_FFFE);  // differs in the low bit only
    issue_request(olpr_pkg::OP_REMOVE, 32'sh5555_5555);  // head
    issue_request(olpr_pkg::OP_REMOVE, 32'shAAAA_AAAA);  // tail
    issue_request(olpr_pkg::OP_REMOVE, 32'sh7FFF_FFFF);
    issue_request(olpr_pkg::OP_REMOVE, 32'sh8000_0000);
    issue_request(olpr_pkg::OP_REMOVE, -1);
    issue_request(olpr_pkg::OP_REMOVE, 0);
    issue_request(olpr_pkg::OP_REMOVE, 0);  // empty again
    wait_results_drained();
  endtask

  task automatic test_full_store(input int rounds);
    logic signed [olpr_pkg::DATA_W-1:0] v;
    repeat (rounds) begin
      while (model_list.size() < LIST_DEPTH)
        issue_request(pick_push(), pick_value());
      repeat (4)
        issue_request(pick_push(), pick_value());
      issue_request(OP_NOP, $urandom);
      // longest search and shift: remove the value at the tail, then the one at the head
      issue_request(olpr_pkg::OP_REMOVE, model_list[model_list.size() - 1]);
      issue_request(olpr_pkg::OP_PUSH_FRONT, pick_value());
      issue_request(olpr_pkg::OP_REMOVE, model_list[0]);
      issue_request(olpr_pkg::OP_PUSH_BACK, pick_value());
      while (model_list.size() != 0) begin
        v = ($urandom_range(0, 9) < 8) ? model_list[$urandom_range(0, model_list.size() - 1)]
                                        : pick_value();
        issue_request(olpr_pkg::OP_REMOVE, v);
      end
      wait_results_drained();
    end
  endtask

  task automatic test_random_mix(input int n_items);
    int r;
    int push_pct;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      push_pct = (model_list.size() < 8) ? 70 : (model_list.size() > 26) ? 40 : 52;
      if (r < 3)
        issue_request(OP_NOP, $urandom);
      else if (r < 3 + push_pct)
        issue_request(pick_push(), pick_value());
      else
        issue_request(olpr_pkg::OP_REMOVE, pick_removal());
      if (k % 150 == 149) wait_results_drained();
    end
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d entry_count %0d", out_status, out_entry_count);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, out_status);
          err_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d actual %0d",
                 want.entry_count, out_entry_count);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store(2);
    test_random_mix(870);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("PASS ordered_list_push_remove");
    else
      $display("FAIL ordered_list_push_remove");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL ordered_list_push_remove");
    $finish;
  end

endmodule

// File: ordered_list_push_remove.f
rtl/core/olpr_pkg.sv
rtl/core/olpr_ram.sv
rtl/core/ordered_list_push_remove.sv
tb/tb_top.sv
